/* hdl/ccr_pkg.sv */
// Shared types and constants for the command completion ring.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package ccr_pkg;

    // Default sizes, used as the defaults of the top-level parameters.
    localparam int RING_DEPTH_DEF  = 16;
    localparam int MAX_PAYLOAD_DEF = 256;

    // One doorbell retires at most this many entries.
    localparam int DRAIN_LIMIT = 16;
    localparam int DRAIN_N_W   = $clog2(DRAIN_LIMIT);

    // Port field widths.
    localparam int WORD_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int OP_W       = 2;
    localparam int OUT_LEN_W  = 9;
    localparam int OUT_CNT_W  = 5;
    localparam int STATUS_W   = 3;
    localparam int IN_TDATA_W = 72;
    localparam int OUT_TDATA_W = 152;

    // Status word bits.
    localparam logic [STATUS_W-1:0] STS_READY = 3'b001;
    localparam logic [STATUS_W-1:0] STS_DONE  = 3'b010;
    localparam logic [STATUS_W-1:0] STS_ERROR = 3'b100;

    // Result kinds.
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_COMP = 1'b1;

    // Input operation codes; the fourth code is ignored.
    typedef enum logic [OP_W-1:0] {
        OP_BYTE  = 2'd0,
        OP_BELL  = 2'd1,
        OP_CLEAR = 2'd2
    } ccr_op_t;

    // Controller states.
    typedef enum logic {
        STATE_IDLE  = 1'b0,
        STATE_DRAIN = 1'b1
    } ccr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_byte;
        logic finish_cmd;
        logic clear_rings;
        logic start_drain;
        logic pop_entry;
    } ccr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic pending_nonzero;
        logic drain_last;
    } ccr_sts_t;

endpackage

`default_nettype wire

/* hdl/command_completion_ring.sv */
// Top level of the command completion ring: controller, datapath and ring store.
// Depends on ccr_pkg, ccr_ctrl, ccr_datapath and ccr_ram.
//
//   Channel | Direction | Transfers
//   s_      | in        | one payload byte, doorbell or ring reset per transfer
//   m_      | out       | one acknowledgment or completion per transfer
//
// Bytes stream one per cycle while the result register is free. A doorbell retires the
// pending entries in order (at most sixteen), each as one completion through the
// result register; s_tready is low meanwhile.
// A finished result waits in an output register; while it waits unread, s_tready is
// low, and a result transfer frees the register for an input transfer in the same cycle.
// Reset is synchronous on aresetn; the ring store needs no clearing pass.
`default_nettype none

module command_completion_ring
    import ccr_pkg::*;
#(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // From bit 0: cmd_code[31:0], cmd_length[63:32], data_byte[71:64].
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // From bit 0: op[1:0].
    input  wire logic [OP_W-1:0]        s_tuser,
    input  wire logic                   s_tlast,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // From bit 0: accept_status[0], code[32:1], length[41:33], seqno[73:42],
    // checksum[105:74], status_word[108:106], cmd_pending_count[113:109],
    // comp_pending_count[118:114], completed_count[150:119], zero fill[151].
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    // From bit 0: kind[0].
    output logic      [0:0]             m_tuser,
    output logic                        m_tlast
);

    localparam int IDX_W   = $clog2(RING_DEPTH);
    localparam int LEN_W   = $clog2(MAX_PAYLOAD + 1);
    localparam int ENTRY_W = 3 * WORD_W + LEN_W;

    ccr_cmd_t           cmd;
    ccr_sts_t           sts;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;
    logic [IDX_W-1:0]   mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;

    // Sequencing of input transfers and doorbell drains.
    ccr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Collector, pointers, counters and result register.
    ccr_datapath #(
        .RING_DEPTH  (RING_DEPTH),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .in_code     (s_tdata[WORD_W-1:0]),
        .in_length   (s_tdata[2*WORD_W-1:WORD_W]),
        .in_byte     (s_tdata[2*WORD_W +: BYTE_W]),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // Ring store: code, length, sequence number and checksum per entry.
    ccr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire

/* hdl/ccr_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module ccr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; a read of the address being written returns old data.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hdl/ccr_ctrl.sv */
// Controller state machine for the command completion ring.
// Depends on ccr_pkg for the state, opcode, command and status types.
`default_nettype none

module ccr_ctrl
    import ccr_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [OP_W-1:0] s_tuser,
    input  wire logic            s_tlast,
    input  wire ccr_sts_t        sts,
    output ccr_cmd_t             cmd
);

    ccr_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            STATE_IDLE: begin
                // An input transfer is taken only when the result register can take a load.
                s_tready = sts.out_free;
                if (s_tvalid && sts.out_free) begin
                    case (s_tuser)
                        OP_BYTE: begin
                            cmd.take_byte  = 1'b1;
                            cmd.finish_cmd = s_tlast;
                        end
                        OP_BELL: begin
                            if (sts.pending_nonzero) begin
                                cmd.start_drain = 1'b1;
                                state_next      = STATE_DRAIN;
                            end
                        end
                        OP_CLEAR: begin
                            cmd.clear_rings = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            STATE_DRAIN: begin
                // One completion per free cycle of the result register.
                if (sts.out_free) begin
                    cmd.pop_entry = 1'b1;
                    if (sts.drain_last) begin
                        state_next = STATE_IDLE;
                    end
                end
            end
            default: begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    // A drain is only started with something to drain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_drain |-> sts.pending_nonzero)
        else $error("drain started with an empty ring");

    // The last pop of a drain returns the controller to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pop_entry && sts.drain_last) |=> (state_reg == STATE_IDLE))
        else $error("drain did not end after its last entry");

    // No input is taken while entries are being retired.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop_entry |-> !(cmd.take_byte || cmd.clear_rings || cmd.start_drain))
        else $error("input taken during a drain");

endmodule

`default_nettype wire

/* hdl/ccr_datapath.sv */
// Datapath for the command completion ring: payload collector, ring pointers,
// counters and the result register. Depends on ccr_pkg; the ring store is external.
`default_nettype none

module ccr_datapath
    import ccr_pkg::*;
#(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    localparam int IDX_W   = $clog2(RING_DEPTH),
    localparam int CNT_W   = $clog2(RING_DEPTH + 1),
    localparam int LEN_W   = $clog2(MAX_PAYLOAD + 1),
    localparam int ENTRY_W = 3 * WORD_W + LEN_W
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire ccr_cmd_t               cmd,
    output ccr_sts_t                    sts,
    input  wire logic [WORD_W-1:0]      in_code,
    input  wire logic [WORD_W-1:0]      in_length,
    input  wire logic [BYTE_W-1:0]      in_byte,
    output logic                        mem_wr_en,
    output logic      [IDX_W-1:0]       mem_wr_addr,
    output logic      [ENTRY_W-1:0]     mem_wr_data,
    output logic      [IDX_W-1:0]       mem_rd_addr,
    input  wire logic [ENTRY_W-1:0]     mem_rd_data,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    output logic      [0:0]             m_tuser,
    output logic                        m_tlast
);

    // Command collector.
    logic                 collecting_reg, collecting_next;
    logic [WORD_W-1:0]    held_code_reg, held_code_next;
    logic [LEN_W-1:0]     held_len_reg, held_len_next;
    logic [LEN_W-1:0]     byte_cnt_reg, byte_cnt_next;
    logic [WORD_W-1:0]    run_sum_reg, run_sum_next;

    // Ring pointers and counters.
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [IDX_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     pending_reg, pending_next;
    logic [CNT_W-1:0]     done_cnt_reg, done_cnt_next;
    logic [WORD_W-1:0]    total_reg, total_next;
    logic [WORD_W-1:0]    next_seq_reg, next_seq_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [DRAIN_N_W-1:0] drain_n_reg, drain_n_next;

    // Result register.
    logic                 out_valid_reg, out_valid_next;
    logic                 out_kind_reg, out_kind_next;
    logic                 out_rej_reg, out_rej_next;
    logic [WORD_W-1:0]    out_code_reg, out_code_next;
    logic [OUT_LEN_W-1:0] out_len_reg, out_len_next;
    logic [WORD_W-1:0]    out_seq_reg, out_seq_next;
    logic [WORD_W-1:0]    out_sum_reg, out_sum_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [OUT_CNT_W-1:0] out_pend_reg, out_pend_next;
    logic [OUT_CNT_W-1:0] out_done_reg, out_done_next;
    logic [WORD_W-1:0]    out_total_reg, out_total_next;
    logic                 out_last_reg, out_last_next;

    // View of the command that the current byte belongs to.
    logic [WORD_W-1:0]    cur_code;
    logic [LEN_W-1:0]     clamped_len;
    logic [LEN_W-1:0]     cur_len;
    logic [LEN_W-1:0]     cur_cnt;
    logic [WORD_W-1:0]    cur_sum;
    logic                 byte_in;
    logic [LEN_W-1:0]     new_cnt;
    logic [WORD_W-1:0]    new_sum;

    logic                 ring_full;
    logic [IDX_W-1:0]     head_inc;
    logic [IDX_W-1:0]     tail_inc;
    logic [CNT_W-1:0]     done_inc;

    // Fields of the entry at the head of the ring.
    logic [WORD_W-1:0]    rd_code;
    logic [LEN_W-1:0]     rd_len;
    logic [WORD_W-1:0]    rd_seq;
    logic [WORD_W-1:0]    rd_sum;

    // The first byte of a command supplies its code and clamped length.
    assign clamped_len = (in_length > WORD_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                            : in_length[LEN_W-1:0];
    assign cur_code = collecting_reg ? held_code_reg : in_code;
    assign cur_len  = collecting_reg ? held_len_reg  : clamped_len;
    assign cur_cnt  = collecting_reg ? byte_cnt_reg  : '0;
    assign cur_sum  = collecting_reg ? run_sum_reg   : '0;

    // Bytes past the clamped length do not count.
    assign byte_in = cur_cnt < cur_len;
    assign new_cnt = byte_in ? cur_cnt + 1'b1 : cur_cnt;
    assign new_sum = byte_in ? cur_sum + WORD_W'(in_byte) : cur_sum;

    // Pointer and counter increments.
    assign ring_full = pending_reg == CNT_W'(RING_DEPTH);
    assign head_inc  = (head_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign done_inc  = (done_cnt_reg == CNT_W'(RING_DEPTH)) ? done_cnt_reg
                                                            : done_cnt_reg + 1'b1;

    // Entry layout, from the top: code, length, sequence number, checksum.
    assign rd_sum  = mem_rd_data[WORD_W-1:0];
    assign rd_seq  = mem_rd_data[2*WORD_W-1:WORD_W];
    assign rd_len  = mem_rd_data[2*WORD_W +: LEN_W];
    assign rd_code = mem_rd_data[2*WORD_W+LEN_W +: WORD_W];

    assign mem_wr_addr = tail_reg;
    assign mem_wr_data = {cur_code, cur_len, next_seq_reg, new_sum};

    // The read address follows the next head, so the read data holds the head entry whenever one is retired.
    assign mem_rd_addr = head_next;

    // Status to the controller.
    assign sts.out_free        = !out_valid_reg || m_tready;
    assign sts.pending_nonzero = pending_reg != '0;
    assign sts.drain_last      = (pending_reg == CNT_W'(1)) ||
                                 (drain_n_reg == DRAIN_N_W'(DRAIN_LIMIT - 1));

    // Next-state logic for the collector, the ring and the result register.
    always_comb begin
        collecting_next = collecting_reg;
        held_code_next  = held_code_reg;
        held_len_next   = held_len_reg;
        byte_cnt_next   = byte_cnt_reg;
        run_sum_next    = run_sum_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        pending_next    = pending_reg;
        done_cnt_next   = done_cnt_reg;
        total_next      = total_reg;
        next_seq_next   = next_seq_reg;
        status_next     = status_reg;
        drain_n_next    = drain_n_reg;
        mem_wr_en       = 1'b0;

        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_rej_next    = out_rej_reg;
        out_code_next   = out_code_reg;
        out_len_next    = out_len_reg;
        out_seq_next    = out_seq_reg;
        out_sum_next    = out_sum_reg;
        out_status_next = out_status_reg;
        out_pend_next   = out_pend_reg;
        out_done_next   = out_done_reg;
        out_total_next  = out_total_reg;
        out_last_next   = out_last_reg;

        if (cmd.clear_rings) begin
            // Ring reset: all but the result register back to reset values.
            collecting_next = 1'b0;
            held_code_next  = '0;
            held_len_next   = '0;
            byte_cnt_next   = '0;
            run_sum_next    = '0;
            head_next       = '0;
            tail_next       = '0;
            pending_next    = '0;
            done_cnt_next   = '0;
            total_next      = '0;
            next_seq_next   = WORD_W'(1);
            status_next     = STS_READY;
            drain_n_next    = '0;
        end else if (cmd.take_byte) begin
            held_code_next = cur_code;
            held_len_next  = cur_len;
            byte_cnt_next  = new_cnt;
            run_sum_next   = new_sum;
            if (!cmd.finish_cmd) begin
                collecting_next = 1'b1;
            end else begin
                // Last byte: store the command if there is room and acknowledge it.
                collecting_next = 1'b0;
                out_valid_next  = 1'b1;
                out_kind_next   = KIND_ACK;
                out_code_next   = cur_code;
                out_len_next    = OUT_LEN_W'(cur_len);
                out_sum_next    = new_sum;
                out_done_next   = OUT_CNT_W'(done_cnt_reg);
                out_total_next  = total_reg;
                out_last_next   = 1'b1;
                if (ring_full) begin
                    out_rej_next    = 1'b1;
                    out_seq_next    = '0;
                    out_status_next = status_reg | STS_ERROR;
                    out_pend_next   = OUT_CNT_W'(pending_reg);
                end else begin
                    mem_wr_en       = 1'b1;
                    next_seq_next   = next_seq_reg + 1'b1;
                    tail_next       = tail_inc;
                    pending_next    = pending_reg + 1'b1;
                    status_next     = STS_READY;
                    out_rej_next    = 1'b0;
                    out_seq_next    = next_seq_reg;
                    out_status_next = STS_READY;
                    out_pend_next   = OUT_CNT_W'(pending_reg + 1'b1);
                end
            end
        end else if (cmd.pop_entry) begin
            // Retire the head entry as one completion.
            head_next       = head_inc;
            pending_next    = pending_reg - 1'b1;
            done_cnt_next   = done_inc;
            total_next      = total_reg + 1'b1;
            status_next     = STS_READY | STS_DONE;
            drain_n_next    = drain_n_reg + 1'b1;
            out_valid_next  = 1'b1;
            out_kind_next   = KIND_COMP;
            out_rej_next    = 1'b0;
            out_code_next   = rd_code;
            out_len_next    = OUT_LEN_W'(rd_len);
            out_seq_next    = rd_seq;
            out_sum_next    = rd_sum;
            out_status_next = STS_READY | STS_DONE;
            out_pend_next   = OUT_CNT_W'(pending_reg - 1'b1);
            out_done_next   = OUT_CNT_W'(done_inc);
            out_total_next  = total_reg + 1'b1;
            out_last_next   = sts.drain_last;
        end

        // A new drain counts its entries from zero.
        if (cmd.start_drain) begin
            drain_n_next = '0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            held_code_reg  <= '0;
            held_len_reg   <= '0;
            byte_cnt_reg   <= '0;
            run_sum_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            pending_reg    <= '0;
            done_cnt_reg   <= '0;
            total_reg      <= '0;
            next_seq_reg   <= WORD_W'(1);
            status_reg     <= STS_READY;
            drain_n_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            collecting_reg <= collecting_next;
            held_code_reg  <= held_code_next;
            held_len_reg   <= held_len_next;
            byte_cnt_reg   <= byte_cnt_next;
            run_sum_reg    <= run_sum_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            pending_reg    <= pending_next;
            done_cnt_reg   <= done_cnt_next;
            total_reg      <= total_next;
            next_seq_reg   <= next_seq_next;
            status_reg     <= status_next;
            drain_n_reg    <= drain_n_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge aclk) begin
        out_kind_reg   <= out_kind_next;
        out_rej_reg    <= out_rej_next;
        out_code_reg   <= out_code_next;
        out_len_reg    <= out_len_next;
        out_seq_reg    <= out_seq_next;
        out_sum_reg    <= out_sum_next;
        out_status_reg <= out_status_next;
        out_pend_reg   <= out_pend_next;
        out_done_reg   <= out_done_next;
        out_total_reg  <= out_total_next;
        out_last_reg   <= out_last_next;
    end

    // Result channel.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_total_reg, out_done_reg, out_pend_reg, out_status_reg,
                       out_sum_reg, out_seq_reg, out_len_reg, out_code_reg, out_rej_reg};

    // The pending count never passes the ring depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= CNT_W'(RING_DEPTH))
        else $error("pending count above ring depth");

    // Entries are retired only while some are pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop_entry |-> (pending_reg != '0))
        else $error("pop from an empty ring");

    // A retired entry or a finished command always leaves a result behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pop_entry || (cmd.take_byte && cmd.finish_cmd)) |=> out_valid_reg)
        else $error("result register not loaded");

    // A completed command stores an entry unless the ring was full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.take_byte && cmd.finish_cmd && !ring_full) |=>
            (pending_reg == $past(pending_reg) + 1'b1))
        else $error("accepted command not counted as pending");

endmodule

`default_nettype wire

/* verif/ccr_checker.sv */
// Checker for the command completion ring: watches both stream channels,
// predicts every acknowledgment and completion, and compares field by field.
// Depends on ccr_pkg for widths, status bits, result kinds and operation codes.

module ccr_checker
    import ccr_pkg::*;
#(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    // From bit 0: cmd_code[31:0], cmd_length[63:32], data_byte[71:64].
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // From bit 0: op[1:0].
    input  logic [OP_W-1:0]        s_tuser,
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // From bit 0: accept_status, code, length, seqno, checksum, status_word,
    // cmd_pending_count, comp_pending_count, completed_count, zero fill.
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    // From bit 0: kind.
    input  logic [0:0]             m_tuser,
    input  logic                   m_tlast,
    output int                     fail_count,
    output int                     replies_open
);

    // One acknowledgment or completion as the block should send it.
    typedef struct {
        logic        kind;
        logic        reject;
        logic [31:0] code;
        logic [8:0]  length;
        logic [31:0] seqno;
        logic [31:0] checksum;
        logic [2:0]  status;
        logic [4:0]  cmd_pend;
        logic [4:0]  comp_pend;
        logic [31:0] completed;
        logic        last;
    } reply_t;

    // Replies predicted but not yet seen on the result channel, oldest first.
    reply_t replies_due[$];
    int     mismatches = 0;

    // Ring store and control state of the predictor.
    logic [31:0] slot_code [RING_DEPTH];
    logic [8:0]  slot_len  [RING_DEPTH];
    logic [31:0] slot_seq  [RING_DEPTH];
    logic [31:0] slot_sum  [RING_DEPTH];
    int          head_pos;
    int          tail_pos;
    int          pend_cnt;
    int          done_cnt;
    logic [31:0] total_done;
    logic [31:0] next_seq;
    logic [2:0]  status_now;
    logic [31:0] held_code;
    logic [8:0]  held_len;
    int          byte_cnt;
    logic [31:0] run_sum;
    logic        collecting;

    // Return the ring to its state after reset; the store keeps its contents.
    task automatic clear_ring();
        head_pos   = 0;
        tail_pos   = 0;
        pend_cnt   = 0;
        done_cnt   = 0;
        total_done = '0;
        next_seq   = 32'd1;
        status_now = STS_READY;
        held_code  = '0;
        held_len   = '0;
        byte_cnt   = 0;
        run_sum    = '0;
        collecting = 1'b0;
    endtask

    // Build a reply, taking the counters as they stand right now.
    function automatic reply_t make_reply(input logic kind, input logic rej,
                                          input logic [31:0] code, input logic [8:0] len,
                                          input logic [31:0] seq, input logic [31:0] sum,
                                          input logic [2:0] st, input logic fin);
        reply_t r;
        r.kind      = kind;
        r.reject    = rej;
        r.code      = code;
        r.length    = len;
        r.seqno     = seq;
        r.checksum  = sum;
        r.status    = st;
        r.cmd_pend  = 5'(pend_cnt);
        r.comp_pend = 5'(done_cnt);
        r.completed = total_done;
        r.last      = fin;
        return r;
    endfunction

    // Advance the ring by one input transfer and queue the replies it causes.
    task automatic ring_step(input logic [OP_W-1:0] op, input logic [31:0] code,
                             input logic [31:0] req, input logic [7:0] data,
                             input logic fin);
        int n;
        int slot;
        if (op == OP_BYTE) begin
            // The first byte of a command latches the command code and clamped length.
            if (!collecting) begin
                held_code  = code;
                held_len   = (req > 32'(MAX_PAYLOAD)) ? 9'(MAX_PAYLOAD) : req[8:0];
                byte_cnt   = 0;
                run_sum    = '0;
                collecting = 1'b1;
            end
            if (byte_cnt < int'(held_len)) begin
                run_sum  = run_sum + 32'(data);
                byte_cnt = byte_cnt + 1;
            end
            if (fin) begin
                collecting = 1'b0;
                if (pend_cnt >= RING_DEPTH) begin
                    // Full ring: no sequence number is used and the status stays.
                    replies_due.push_back(make_reply(KIND_ACK, 1'b1, held_code, held_len,
                                                     '0, run_sum, status_now | STS_ERROR,
                                                     1'b1));
                end else begin
                    slot_code[tail_pos] = held_code;
                    slot_len[tail_pos]  = held_len;
                    slot_seq[tail_pos]  = next_seq;
                    slot_sum[tail_pos]  = run_sum;
                    tail_pos   = (tail_pos + 1) % RING_DEPTH;
                    pend_cnt   = pend_cnt + 1;
                    status_now = STS_READY;
                    replies_due.push_back(make_reply(KIND_ACK, 1'b0, held_code, held_len,
                                                     next_seq, run_sum, status_now, 1'b1));
                    next_seq = next_seq + 32'd1;
                end
            end
        end else if (op == OP_BELL) begin
            // Retire pending entries in order, one completion each.
            n = 0;
            while (pend_cnt > 0 && n < DRAIN_LIMIT) begin
                slot       = head_pos;
                status_now = STS_READY | STS_DONE;
                total_done = total_done + 32'd1;
                if (done_cnt < RING_DEPTH) begin
                    done_cnt = done_cnt + 1;
                end
                head_pos = (head_pos + 1) % RING_DEPTH;
                pend_cnt = pend_cnt - 1;
                replies_due.push_back(make_reply(KIND_COMP, 1'b0, slot_code[slot],
                                                 slot_len[slot], slot_seq[slot],
                                                 slot_sum[slot], status_now,
                                                 pend_cnt == 0 || n + 1 == DRAIN_LIMIT));
                n = n + 1;
            end
        end else if (op == OP_CLEAR) begin
            clear_ring();
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatches = mismatches + 1;
        $display("[%0t] ccr mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
        end
    endtask

    // Compare result transfers first, since they stem from earlier inputs,
    // then feed the input transfer of this edge to the predictor.
    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            clear_ring();
            replies_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    report_mismatch("result transfer with no reply outstanding");
                end else begin
                    want = replies_due.pop_front();
                    check_field("kind", m_tuser[0], want.kind);
                    check_field("accept_status", m_tdata[0], want.reject);
                    check_field("code", m_tdata[32:1], want.code);
                    check_field("length", m_tdata[41:33], want.length);
                    check_field("seqno", m_tdata[73:42], want.seqno);
                    check_field("checksum", m_tdata[105:74], want.checksum);
                    check_field("status_word", m_tdata[108:106], want.status);
                    check_field("cmd_pending_count", m_tdata[113:109], want.cmd_pend);
                    check_field("comp_pending_count", m_tdata[118:114], want.comp_pend);
                    check_field("completed_count", m_tdata[150:119], want.completed);
                    check_field("zero fill", m_tdata[151], 1'b0);
                    check_field("tlast", m_tlast, want.last);
                end
            end
            if (s_tvalid && s_tready) begin
                ring_step(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[71:64], s_tlast);
            end
        end
        fail_count   <= mismatches;
        replies_open <= replies_due.size();
    end

endmodule

/* verif/tb_command_completion_ring.sv */
// Testbench top for the command completion ring: clock, reset, stimulus and verdict.
// Depends on ccr_pkg, command_completion_ring and ccr_checker.

module tb_command_completion_ring;
    import ccr_pkg::*;

    // The fourth operation code, which the block ignores.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 330;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_TAIL   = 40;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [OP_W-1:0]        s_tuser  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;
    logic                   m_tlast;

    int fail_count;
    int replies_open;
    int items_sent   = 0;
    bit tx_steady    = 1'b0;
    int quiet_cycles = 0;
    int stall_left   = 0;
    int rx_phase     = 0;
    bit rx_steady    = 1'b0;

    command_completion_ring dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    ccr_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .replies_open (replies_open)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle length before an input transfer: mostly none or short, a few long.
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_steady || r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Drive one input transfer and return at the edge that accepts it.
    // Valid stays high so that a following transfer can go back to back.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [31:0] code,
                             input logic [31:0] req, input logic [7:0] data,
                             input logic fin);
        int gap;
        bit took;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {data, req, code};
        s_tlast  <= fin;
        // Ready is sampled mid-cycle, where it is settled for the coming edge.
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        if (op != OP_SPARE) begin
            items_sent = items_sent + 1;
        end
    endtask

    // A command of nitems byte transfers; later items carry random ignored fields.
    task automatic send_command(input logic [31:0] req, input int nitems);
        logic [31:0] code;
        code = $urandom;
        for (int i = 0; i < nitems; i++) begin
            // Now and then a doorbell lands in the middle of a command.
            if (i > 0 && $urandom_range(0, 99) < 3) begin
                send_item(OP_BELL, $urandom, $urandom, 8'($urandom), 1'($urandom));
            end
            send_item(OP_BYTE, (i == 0) ? code : $urandom, (i == 0) ? req : $urandom,
                      8'($urandom), i == nitems - 1);
        end
    endtask

    // Hold the input side idle until every outstanding reply has come.
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (replies_open == 0);
        @(posedge aclk);
    endtask

    // Result side: random stalls with quiet phases of full throughput.
    always @(posedge aclk) begin
        if (rx_phase == 0) begin
            rx_phase  = $urandom_range(50, 300);
            rx_steady = ($urandom_range(0, 3) == 0);
        end else begin
            rx_phase = rx_phase - 1;
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready  <= 1'b0;
        end else if (!rx_steady && $urandom_range(0, 99) < 30) begin
            if ($urandom_range(0, 99) < 75) begin
                stall_left = $urandom_range(0, 2);
            end else if ($urandom_range(0, 99) < 85) begin
                stall_left = $urandom_range(3, 11);
            end else begin
                stall_left = $urandom_range(30, 60);
            end
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: too long without any transfer on either channel ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int          r;
        int          bell_pct;
        int          phase_left;
        int          clamp;
        int          nitems;
        logic [31:0] req;
        bit          paused;

        bell_pct   = 10;
        phase_left = 0;
        paused     = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: ignored code and a doorbell with nothing pending.
        send_item(OP_SPARE, '1, '1, 8'hFF, 1'b1);
        send_item(OP_BELL, '0, '0, 8'h00, 1'b0);
        // Largest code and length: clamped, and short since one byte arrives.
        send_item(OP_BYTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        // Zero length: every byte is ignored and later fields are not latched.
        send_item(OP_BYTE, 32'h0000_0000, 32'h0000_0000, 8'h55, 1'b0);
        send_item(OP_BYTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hAA, 1'b1);
        // Two-byte command with a doorbell inside it and one byte past its length.
        send_item(OP_BYTE, 32'h1234_5678, 32'd2, 8'h80, 1'b0);
        send_item(OP_BELL, '0, '0, 8'h00, 1'b0);
        send_item(OP_BYTE, 32'h0000_0000, 32'h0000_0000, 8'h7F, 1'b0);
        send_item(OP_BYTE, 32'h0000_0000, 32'h0000_0000, 8'hFF, 1'b1);
        // Fill the ring, then one more command, which is rejected.
        repeat (15) send_item(OP_BYTE, $urandom, 32'd1, 8'($urandom), 1'b1);
        send_item(OP_BYTE, 32'hA5A5_5A5A, 32'd5, 8'h01, 1'b1);
        // Drain all sixteen; the completion count saturates.
        send_item(OP_BELL, '0, '0, 8'h00, 1'b0);
        // Ring reset with a command half collected.
        send_item(OP_BYTE, 32'h0F0F_F0F0, 32'd10, 8'h33, 1'b0);
        send_item(OP_CLEAR, '1, '1, 8'hFF, 1'b1);
        drain_replies();

        // Random phase: mostly well-formed commands, with doorbells at a rate
        // that changes per phase so the ring both fills up and empties.
        while (items_sent < RANDOM_ITEMS) begin
            if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                drain_replies();
            end
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 60);
                bell_pct   = $urandom_range(3, 35);
                tx_steady  = ($urandom_range(0, 3) == 0);
            end
            phase_left = phase_left - 1;
            r = $urandom_range(0, 99);
            if (r < bell_pct) begin
                send_item(OP_BELL, $urandom, $urandom, 8'($urandom), 1'($urandom));
            end else if (r < bell_pct + 2) begin
                send_item(OP_CLEAR, $urandom, $urandom, 8'($urandom), 1'($urandom));
            end else if (r < bell_pct + 5) begin
                send_item(OP_SPARE, $urandom, $urandom, 8'($urandom), 1'($urandom));
            end else if (r < bell_pct + 9) begin
                // Stray byte with random fields; may leave a command open.
                send_item(OP_BYTE, $urandom, $urandom, 8'($urandom), 1'($urandom));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 95) begin
                    req    = (r < 75) ? $urandom_range(0, 6) : $urandom_range(7, 40);
                    clamp  = int'(req);
                    nitems = (clamp > 0) ? clamp : 1;
                    r      = $urandom_range(0, 99);
                    if (r < 15) begin
                        nitems = $urandom_range(1, nitems);
                    end else if (r < 30) begin
                        nitems = clamp + $urandom_range(1, 3);
                    end
                end else if (r < 99 || items_sent + MAX_PAYLOAD_DEF + 2 >= RANDOM_ITEMS) begin
                    // Huge requested length, clamped; payload cut short. Also taken
                    // when a full-size payload would run far past the item budget.
                    req    = $urandom;
                    nitems = $urandom_range(1, 6);
                end else begin
                    // Rare full-size payload around the maximum.
                    req    = $urandom_range(MAX_PAYLOAD_DEF - 6, MAX_PAYLOAD_DEF + 4);
                    nitems = MAX_PAYLOAD_DEF + $urandom_range(0, 2);
                end
                send_command(req, nitems);
            end
        end

        drain_replies();
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (fail_count == 0 && replies_open == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
